FILE: rtl/core/uri_dec_pkg.sv
// ----------------------------------------------------------------------------
// URI percent decoder package
// Shared payload types, decoder op types, constants and character helpers.
// ----------------------------------------------------------------------------
package uri_dec_pkg;

  // Input transaction: one character of the encoded string
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } uri_in_t;

  // Output transaction: one decoded character or an error mark
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_error;
    logic       out_end;
  } uri_out_t;

  // Escape phase of the front end; the fourth code is treated as idle
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_HEX  = 2'd2
  } phase_e;

  // Work handed from front to back
  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_TRIPLE = 2'd1,
    OP_ERROR  = 2'd2
  } op_kind_e;

  typedef struct packed {
    op_kind_e   kind;
    logic [7:0] byte_a;  // decoded byte, or first hex digit of a kept escape
    logic [7:0] byte_b;  // second hex digit of a kept escape
    logic       last;
  } uri_op_t;

  // Op queue geometry
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // Result index within a kept escape
  localparam logic [1:0] PartFirst = 2'd0;
  localparam logic [1:0] PartMid   = 2'd1;
  localparam logic [1:0] PartLast  = 2'd2;

  // Characters
  localparam logic [7:0] ChPercent    = 8'h25;
  localparam logic [7:0] ChZero       = 8'h30;
  localparam logic [7:0] ChNine       = 8'h39;
  localparam logic [7:0] ChLowA       = 8'h61;
  localparam logic [7:0] ChLowF       = 8'h66;
  localparam logic [7:0] ChUpA        = 8'h41;
  localparam logic [7:0] ChUpF        = 8'h46;
  localparam logic [3:0] HexLetterOfs = 4'hA;

  // True for a hex digit in either case
  function automatic logic hex_ok(logic [7:0] ch);
    return ((ch >= ChZero) && (ch <= ChNine)) ||
           ((ch >= ChLowA) && (ch <= ChLowF)) ||
           ((ch >= ChUpA)  && (ch <= ChUpF));
  endfunction

  // Nibble value of a hex digit; meaningless for other characters
  function automatic logic [3:0] hex_nib(logic [7:0] ch);
    logic [7:0] ofs;
    if ((ch >= ChZero) && (ch <= ChNine)) begin
      ofs = ch - ChZero;
      return ofs[3:0];
    end else if ((ch >= ChLowA) && (ch <= ChLowF)) begin
      ofs = ch - ChLowA;
      return ofs[3:0] + HexLetterOfs;
    end else begin
      ofs = ch - ChUpA;
      return ofs[3:0] + HexLetterOfs;
    end
  endfunction

  // Characters kept escaped in full URI mode: ; / ? : @ & = + $ , #
  function automatic logic is_reserved(logic [7:0] ch);
    logic hit;
    case (ch)
      8'h3B, 8'h2F, 8'h3F, 8'h3A, 8'h40, 8'h26,
      8'h3D, 8'h2B, 8'h24, 8'h2C, 8'h23: hit = 1'b1;
      default:                           hit = 1'b0;
    endcase
    return hit;
  endfunction

  // Continuations expected after a UTF-8 lead byte: leading ones less one
  function automatic logic [2:0] lead_count(logic [7:0] c);
    logic [3:0] ones;
    logic       run;
    ones = 4'd0;
    run  = 1'b1;
    for (int i = 7; i >= 0; i--) begin
      if (run && c[i]) begin
        ones = ones + 4'd1;
      end else begin
        run = 1'b0;
      end
    end
    if (ones != 4'd0) begin
      ones = ones - 4'd1;
    end
    return ones[2:0];
  endfunction

endpackage

FILE: rtl/core/uri_percent_decoder.sv
// ----------------------------------------------------------------------------
// URI percent decoder, top level
// Throughput: one input character per cycle unless the op queue is full;
// results leave at one per cycle unless the output stalls, a kept reserved
// escape giving three results from its op queue entry.
// Reset: asynchronous, active low; clears escape state, queue and output valid,
// and sets full URI mode.
// ----------------------------------------------------------------------------
module uri_percent_decoder (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  uri_dec_pkg::uri_in_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output uri_dec_pkg::uri_out_t out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_data_i
);
  import uri_dec_pkg::*;

  logic    push;
  logic    pop;
  logic    full;
  logic    empty;
  uri_op_t op;
  uri_op_t head;

  // Classify characters
  uri_dec_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .full_i      (full),
    .push_o      (push),
    .op_o        (op)
  );

  // Queue ops
  uri_dec_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (op),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  // Emit results
  uri_dec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: rtl/core/uri_dec_front.sv
// ----------------------------------------------------------------------------
// URI decoder front end
// Accepts characters, tracks escape and UTF-8 state, and queues decoder ops.
// ----------------------------------------------------------------------------
module uri_dec_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  uri_dec_pkg::uri_in_t in_item_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_data_i,
  input  logic                 full_i,
  output logic                 push_o,
  output uri_dec_pkg::uri_op_t op_o
);
  import uri_dec_pkg::*;

  logic       keep_q;
  phase_e     phase_q, phase_d;
  logic [7:0] first_q, first_d;
  logic [2:0] pend_q, pend_d;
  logic       drop_q, drop_d;
  logic       accept;
  logic       fail;
  logic [7:0] ch;
  logic       last;
  logic [7:0] decoded;

  // Hold off input while the op queue is full
  assign in_stall_o  = full_i;
  assign accept      = in_valid_i && !full_i;
  assign cfg_ready_o = 1'b1;

  assign ch      = in_item_i.in_byte;
  assign last    = in_item_i.in_last;
  assign decoded = {hex_nib(first_q), hex_nib(ch)};

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      keep_q <= cfg_data_i;
    end
  end

  // Classify the character and advance escape state
  always_comb begin
    phase_d     = phase_q;
    first_d     = first_q;
    pend_d      = pend_q;
    drop_d      = drop_q;
    fail        = 1'b0;
    push_o      = 1'b0;
    op_o.kind   = OP_BYTE;
    op_o.byte_a = ch;
    op_o.byte_b = 8'h00;
    op_o.last   = last;
    if (accept) begin
      if (drop_q) begin
        if (last) begin
          drop_d  = 1'b0;
          phase_d = PH_IDLE;
          first_d = 8'h00;
          pend_d  = 3'd0;
        end
      end else begin
        case (phase_q)
          PH_PCT: begin
            if (!hex_ok(ch) || last) begin
              fail = 1'b1;
            end else begin
              first_d = ch;
              phase_d = PH_HEX;
            end
          end
          PH_HEX: begin
            if (!hex_ok(first_q) || !hex_ok(ch)) begin
              fail = 1'b1;
            end else begin
              pend_d  = (pend_q == 3'd0) ? lead_count(decoded) : pend_q - 3'd1;
              phase_d = PH_IDLE;
              first_d = 8'h00;
              push_o  = 1'b1;
              if (keep_q && is_reserved(decoded)) begin
                op_o.kind   = OP_TRIPLE;
                op_o.byte_a = first_q;
                op_o.byte_b = ch;
              end else begin
                op_o.byte_a = decoded;
              end
              if (last) begin
                pend_d = 3'd0;
              end
            end
          end
          default: begin
            if (ch == ChPercent) begin
              if (last) begin
                fail = 1'b1;
              end else begin
                phase_d = PH_PCT;
              end
            end else if (pend_q != 3'd0) begin
              fail = 1'b1;
            end else begin
              push_o  = 1'b1;
              phase_d = PH_IDLE;
            end
          end
        endcase
        // Abort the string: one error result, drop the rest
        if (fail) begin
          push_o      = 1'b1;
          op_o.kind   = OP_ERROR;
          op_o.byte_a = 8'h00;
          op_o.last   = 1'b1;
          phase_d     = PH_IDLE;
          first_d     = 8'h00;
          pend_d      = 3'd0;
          drop_d      = !last;
        end
      end
    end
  end

  // Escape state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      first_q <= 8'h00;
      pend_q  <= 3'd0;
      drop_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      first_q <= first_d;
      pend_q  <= pend_d;
      drop_q  <= drop_d;
    end
  end

  // Dropping only follows an abort, which clears all escape state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop_q |-> (phase_q == PH_IDLE) && (pend_q == 3'd0))
    else $error("front: dropping with escape state open");

  // Second digit phase only entered with a valid first digit stored
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HEX) |-> hex_ok(first_q))
    else $error("front: stored first digit is not hex");

endmodule

FILE: rtl/core/uri_dec_fifo.sv
// ----------------------------------------------------------------------------
// URI decoder op queue
// Short register queue decoupling the front end from the result sequencer.
// ----------------------------------------------------------------------------
module uri_dec_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  uri_dec_pkg::uri_op_t op_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output uri_dec_pkg::uri_op_t head_o
);
  import uri_dec_pkg::*;

  uri_op_t               mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0]   count_q;

  assign full_o  = (count_q == FifoCntW'(FifoDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Store pushed ops
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + FifoPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + FifoPtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + FifoCntW'(1);
        2'b01:   count_q <= count_q - FifoCntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("fifo: push while full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("fifo: pop while empty");

endmodule

FILE: rtl/core/uri_dec_back.sv
// ----------------------------------------------------------------------------
// URI decoder result sequencer
// Expands queued ops into one or three results behind an output register.
// ----------------------------------------------------------------------------
module uri_dec_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  uri_dec_pkg::uri_op_t  head_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output uri_dec_pkg::uri_out_t out_item_o
);
  import uri_dec_pkg::*;

  logic [1:0] part_q, part_d;
  logic       valid_q, valid_d;
  uri_out_t   item_q, item_d;
  logic       load;
  logic       done;

  // Load a new result when the output register is free or being taken
  assign load = !empty_i && (!valid_q || !out_stall_i);
  assign done = (head_i.kind != OP_TRIPLE) || (part_q == PartLast);
  assign pop_o = load && done;

  // Select the current result of the head op
  always_comb begin
    item_d.out_byte  = head_i.byte_a;
    item_d.out_error = 1'b0;
    item_d.out_end   = head_i.last;
    case (head_i.kind)
      OP_TRIPLE: begin
        case (part_q)
          PartFirst: begin
            item_d.out_byte = ChPercent;
            item_d.out_end  = 1'b0;
          end
          PartMid: begin
            item_d.out_byte = head_i.byte_a;
            item_d.out_end  = 1'b0;
          end
          default: begin
            item_d.out_byte = head_i.byte_b;
          end
        endcase
      end
      OP_ERROR: begin
        item_d.out_byte  = 8'h00;
        item_d.out_error = 1'b1;
        item_d.out_end   = 1'b1;
      end
      default: begin
        item_d.out_byte = head_i.byte_a;
      end
    endcase
  end

  // Next part index and output valid
  always_comb begin
    part_d  = part_q;
    valid_d = valid_q && out_stall_i;
    if (load) begin
      valid_d = 1'b1;
      part_d  = done ? PartFirst : part_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q  <= PartFirst;
      valid_q <= 1'b0;
    end else begin
      part_q  <= part_d;
      valid_q <= valid_d;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  // A kept escape in progress stays at the queue head until its last part
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (part_q != PartFirst) |-> (!empty_i && (head_i.kind == OP_TRIPLE)))
    else $error("back: part index open without a kept escape at head");

endmodule

FILE: bench/uri_percent_decoder_tb.sv
// ----------------------------------------------------------------------------
// URI percent decoder testbench
// Streams encoded strings into the decoder and checks every result, field by
// field and in order, against a behavioural predictor. A short table of
// strings covers the corner cases first. Random strings follow, in both
// decode modes, with idle bursts on both channels, one long output hold-off
// and one drain pause.
// ----------------------------------------------------------------------------
module uri_percent_decoder_tb;
  import uri_dec_pkg::*;

  localparam int SettleCycles = 6;
  localparam int HoldCycles   = 300;
  localparam int QuietLimit   = 3000;
  localparam int MaxReports   = 10;

  // One row of the directed table; want is used only where typed is set
  typedef struct packed {
    logic [7:0] ch;
    logic       lst;
    logic       typed;
    uri_out_t   want;
  } dir_row_t;

  localparam uri_out_t NoWant  = '0;
  localparam uri_out_t ErrMark = '{8'h00, 1'b1, 1'b1};

  localparam dir_row_t DirRows [0:23] = '{
    // plain characters, extremes of the byte
    '{8'h61, 1'b1, 1'b1, '{8'h61, 1'b0, 1'b1}},
    '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b0, 1'b1}},
    // lone percent at the end of a string
    '{ChPercent, 1'b1, 1'b1, ErrMark},
    // bad first hex digit, then drop to the end of the string
    '{ChPercent, 1'b0, 1'b0, NoWant},
    '{8'h47, 1'b0, 1'b1, ErrMark},
    '{8'h78, 1'b0, 1'b0, NoWant},
    '{ChPercent, 1'b1, 1'b0, NoWant},
    // %2F: kept as three characters in full URI mode
    '{ChPercent, 1'b0, 1'b0, NoWant},
    '{8'h32, 1'b0, 1'b0, NoWant},
    '{8'h46, 1'b0, 1'b0, NoWant},
    // %c3 opens a two byte sequence; a literal then is an error
    '{ChPercent, 1'b0, 1'b0, NoWant},
    '{8'h63, 1'b0, 1'b0, NoWant},
    '{8'h33, 1'b0, 1'b0, NoWant},
    '{8'h7A, 1'b1, 1'b1, ErrMark},
    // escape cut short after its first digit
    '{ChPercent, 1'b0, 1'b0, NoWant},
    '{8'h34, 1'b1, 1'b1, ErrMark},
    // bad second hex digit, then drop
    '{ChPercent, 1'b0, 1'b0, NoWant},
    '{8'h61, 1'b0, 1'b0, NoWant},
    '{8'h23, 1'b0, 1'b1, ErrMark},
    '{8'h71, 1'b1, 1'b0, NoWant},
    // %Ff: mixed case, all ones byte closing the string
    '{ChPercent, 1'b0, 1'b0, NoWant},
    '{8'h46, 1'b0, 1'b0, NoWant},
    '{8'h66, 1'b1, 1'b0, NoWant}
  };

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  uri_in_t  in_item;
  logic     out_valid;
  logic     out_stall;
  uri_out_t out_item;
  logic     cfg_valid;
  logic     cfg_ready;
  logic     cfg_data;

  // Predictor state and configuration
  phase_e     esc_phase;
  logic [7:0] hex_hi;
  logic [2:0] cont_left;
  logic       drop_rest;
  logic       keep_mode;

  uri_out_t   step_res[$];
  uri_out_t   expected_chars[$];
  logic [7:0] str_buf[$];

  int  n_items;
  int  n_results;
  int  n_err_marks;
  int  n_kept;
  int  n_mismatch;
  int  quiet_cycles;
  int  hold_asked;
  int  hold_done;
  bit  tx_idle_en;
  bit  rx_idle_en;

  uri_percent_decoder DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always #2 clk = ~clk;

  // Hex digit value, or -1 for any other character
  function automatic int nibble_of(logic [7:0] ch);
    if (ch >= 8'h30 && ch <= 8'h39) return int'(ch) - 'h30;
    if (ch >= 8'h61 && ch <= 8'h66) return int'(ch) - 'h61 + 10;
    if (ch >= 8'h41 && ch <= 8'h46) return int'(ch) - 'h41 + 10;
    return -1;
  endfunction

  // Reserved characters ; / ? : @ & = + $ , # left escaped in full URI mode
  function automatic bit kept_in_uri(logic [7:0] ch);
    case (ch)
      8'h3B, 8'h2F, 8'h3F, 8'h3A, 8'h40, 8'h26,
      8'h3D, 8'h2B, 8'h24, 8'h2C, 8'h23: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Leading one bits less one: continuations a lead byte announces
  function automatic int utf8_tail(logic [7:0] c);
    int ones;
    ones = 0;
    while (ones < 8 && c[7 - ones]) ones++;
    return (ones > 0) ? ones - 1 : 0;
  endfunction

  function automatic void clear_string_state();
    esc_phase = PH_IDLE;
    hex_hi    = 8'h00;
    cont_left = 3'd0;
    drop_rest = 1'b0;
  endfunction

  // Emit the error mark and drop the rest of the string
  function automatic void abort_string(logic lst);
    step_res.push_back(ErrMark);
    n_err_marks++;
    clear_string_state();
    if (!lst) drop_rest = 1'b1;
  endfunction

  // Work out the results one input character causes
  function automatic void decode_char(uri_in_t it);
    logic [7:0] b;
    logic [7:0] c;
    logic       lst;
    int         hi;
    int         lo;
    b   = it.in_byte;
    lst = it.in_last;
    step_res.delete();
    if (drop_rest) begin
      if (lst) clear_string_state();
      return;
    end
    case (esc_phase)
      PH_PCT: begin
        if (nibble_of(b) < 0 || lst) begin
          abort_string(lst);
          return;
        end
        hex_hi    = b;
        esc_phase = PH_HEX;
      end
      PH_HEX: begin
        hi = nibble_of(hex_hi);
        lo = nibble_of(b);
        if (hi < 0 || lo < 0) begin
          abort_string(lst);
          return;
        end
        c = 8'(hi * 16 + lo);
        if (cont_left == 3'd0) begin
          cont_left = 3'(utf8_tail(c));
        end else begin
          cont_left = cont_left - 3'd1;
        end
        esc_phase = PH_IDLE;
        if (keep_mode && kept_in_uri(c)) begin
          step_res.push_back(uri_out_t'{ChPercent, 1'b0, 1'b0});
          step_res.push_back(uri_out_t'{hex_hi, 1'b0, 1'b0});
          step_res.push_back(uri_out_t'{b, 1'b0, lst});
          n_kept++;
        end else begin
          step_res.push_back(uri_out_t'{c, 1'b0, lst});
        end
        hex_hi = 8'h00;
        if (lst) clear_string_state();
      end
      default: begin
        if (b == ChPercent) begin
          if (lst) abort_string(lst);
          else esc_phase = PH_PCT;
          return;
        end
        if (cont_left != 3'd0) begin
          abort_string(lst);
          return;
        end
        step_res.push_back(uri_out_t'{b, 1'b0, lst});
        if (lst) clear_string_state();
      end
    endcase
  endfunction

  // Offer one character, hold it until taken, then record its results
  task automatic drive_item(logic [7:0] ch, logic lst, logic typed, uri_out_t want);
    uri_in_t it;
    it = uri_in_t'{ch, lst};
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_items++;
    decode_char(it);
    if (typed) begin
      expected_chars.push_back(want);
    end else begin
      foreach (step_res[i]) expected_chars.push_back(step_res[i]);
    end
  endtask

  // Stop sending and wait until every result is out and the pipe is empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_mode(logic mode);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    keep_mode = mode;
  endtask

  // Random hex digit character, either case
  function automatic logic [7:0] hex_digit(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    if ($urandom_range(0, 1) == 0) return 8'h41 + 8'(n) - 8'd10;
    return 8'h61 + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] not_hex();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (nibble_of(v) >= 0);
    return v;
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == ChPercent);
    return v;
  endfunction

  function automatic void put_escape(logic [7:0] v);
    str_buf.push_back(ChPercent);
    str_buf.push_back(hex_digit(v[7:4]));
    str_buf.push_back(hex_digit(v[3:0]));
  endfunction

  // Build one string, mostly well formed, and send it
  task automatic send_random_string();
    logic [7:0] reserved_set [0:10];
    logic [7:0] lead;
    int         n_tok;
    int         pick;
    int         tail;
    reserved_set = '{8'h3B, 8'h2F, 8'h3F, 8'h3A, 8'h40, 8'h26,
                     8'h3D, 8'h2B, 8'h24, 8'h2C, 8'h23};
    str_buf.delete();
    n_tok = $urandom_range(1, 8);
    repeat (n_tok) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        str_buf.push_back(plain_char());
      end else if (pick < 55) begin
        put_escape(8'($urandom_range(0, 8'hBF)));
      end else if (pick < 70) begin
        put_escape(reserved_set[$urandom_range(0, 10)]);
      end else if (pick < 87) begin
        // lead byte with its continuations, now and then one short
        lead = 8'($urandom_range(8'hC0, 8'hFF));
        tail = utf8_tail(lead);
        if ($urandom_range(0, 3) == 0) tail--;
        put_escape(lead);
        repeat (tail) put_escape(8'($urandom_range(8'h80, 8'hBF)));
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            str_buf.push_back(ChPercent);
            str_buf.push_back(not_hex());
          end
          1: begin
            str_buf.push_back(ChPercent);
            str_buf.push_back(hex_digit(4'($urandom_range(0, 15))));
            str_buf.push_back(not_hex());
          end
          2: begin
            put_escape(8'($urandom_range(8'hC0, 8'hFF)));
            str_buf.push_back(plain_char());
          end
          default: str_buf.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
    // now and then cut the final escape short
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      str_buf.push_back(ChPercent);
    end else if (pick == 1) begin
      str_buf.push_back(ChPercent);
      str_buf.push_back(hex_digit(4'($urandom_range(0, 15))));
    end
    foreach (str_buf[i]) begin
      drive_item(str_buf[i], (i == str_buf.size() - 1), 1'b0, NoWant);
    end
  endtask

  task automatic random_phase(int upto, bit with_pause);
    while (n_items < upto) begin
      send_random_string();
      if (with_pause && n_items >= upto - 50) begin
        wait_idle();
        with_pause = 1'b0;
      end
    end
  endtask

  // Receiver: random stall bursts, plus a long hold-off when asked
  initial begin
    out_stall = 1'b0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (hold_done != hold_asked) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        out_stall <= 1'b0;
        hold_done = hold_asked;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    uri_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (expected_chars.size() == 0) begin
        if (n_mismatch < MaxReports) begin
          $display("unexpected result: byte %02h err %0b end %0b",
                   out_item.out_byte, out_item.out_error, out_item.out_end);
        end
        n_mismatch++;
      end else begin
        want = expected_chars.pop_front();
        if (out_item.out_byte !== want.out_byte || out_item.out_error !== want.out_error ||
            out_item.out_end !== want.out_end) begin
          if (n_mismatch < MaxReports) begin
            $display("mismatch: expected byte %02h err %0b end %0b, got byte %02h err %0b end %0b",
                     want.out_byte, want.out_error, want.out_end,
                     out_item.out_byte, out_item.out_error, out_item.out_end);
          end
          n_mismatch++;
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("watchdog: no transaction for %0d cycles, %0d results still due",
               QuietLimit, expected_chars.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_item      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = 1'b0;
    hold_asked   = 0;
    quiet_cycles = 0;
    n_items      = 0;
    n_results    = 0;
    n_err_marks  = 0;
    n_kept       = 0;
    n_mismatch   = 0;
    tx_idle_en   = 1'b1;
    rx_idle_en   = 1'b1;
    keep_mode    = 1'b1;
    clear_string_state();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed strings in the reset mode
    foreach (DirRows[i]) begin
      drive_item(DirRows[i].ch, DirRows[i].lst, DirRows[i].typed, DirRows[i].want);
    end

    // Component mode, with a drain pause part way through
    write_mode(1'b0);
    random_phase(130, 1'b1);

    // Full URI mode, opening with a long output hold-off
    write_mode(1'b1);
    hold_asked++;
    random_phase(230, 1'b0);

    write_mode(1'b0);
    random_phase(330, 1'b0);

    // Last stretch at full rate on both sides
    write_mode(1'b1);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    random_phase(420, 1'b0);

    wait_idle();
    n_mismatch += expected_chars.size();
    $display("Decoded %0d characters into %0d results (%0d error marks, %0d kept escapes)",
             n_items, n_results, n_err_marks, n_kept);
    $display("across both decode modes; %0d mismatches", n_mismatch);
    if (n_mismatch == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
